FILE: rtl/core/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the sliding window correlator
// Sample and control types used by the window stores, the multiply-accumulate
// datapath and the top level.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned ACC_W    = 42;
  localparam int unsigned REQ_W    = 2;

  // Request codes carried by req_type_i.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_X = 2'd0,
    REQ_ADD_Y = 2'd1,
    REQ_CLR_X = 2'd2,
    REQ_CLR_Y = 2'd3
  } req_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } sample_t;

  // Control from the sequencer to one window store.
  typedef struct packed {
    logic add;    // write the new sample and advance the ring
    logic clear;  // empty the window
    logic rd;     // read one entry of the sweep
    logic first;  // this read is the first of the sweep
  } win_ctrl_t;

endpackage

FILE: rtl/core/sliding_window_correlator_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_correlator_unit: sliding window dot-product correlator
// Two windows of complex Q15 samples; every request updates one window and
// returns the exact dot product of both windows.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ------------------------------
//  request   in         in_valid_i / in_stall_o   req_type_i, sample_re_i/_im_i
//  result    out        out_valid_o / out_stall_i corr_re_o, corr_im_o
//  config    in         cfg_we_i (no wait)        cfg_data_i (complex mode)
//
//  A request passes through these steps: it is accepted and written into the
//  window memory, a sweep follows in which the single read port of each
//  window memory feeds one multiply-accumulate per entry, the read and
//  product registers drain, and the result is loaded. The result register
//  frees the input side, so a new request may be accepted while the previous
//  result is still stalled; a finished sum waits in the accumulator until
//  the result register is free.
//  Reset empties both windows through their fill counts; no memory clearing
//  pass is needed and requests are taken right after reset.
//
module sliding_window_correlator_unit import swc_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic signed [SAMPLE_W-1:0] sample_re_i,
  input  logic signed [SAMPLE_W-1:0] sample_im_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ACC_W-1:0]    corr_re_o,
  output logic signed [ACC_W-1:0]    corr_im_o,
  // Configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_data_i
);

  localparam int unsigned AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           cnt_q;
  logic                    complex_q;
  logic                    out_valid_q;
  logic signed [ACC_W-1:0] corr_re_q;
  logic signed [ACC_W-1:0] corr_im_q;

  logic                    accept;
  logic                    sweep_last;
  logic                    finished;
  logic                    load;
  req_e                    req;
  sample_t                 wr_sample;
  win_ctrl_t               x_ctrl, y_ctrl;
  sample_t                 x_sample, y_sample;
  logic                    x_strobe, y_strobe;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] acc_re, acc_im;

  assign req        = req_e'(req_type_i);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign sweep_last = (cnt_q == AW'(WINDOW_LENGTH - 1));

  // The sum is final once no read or product is left in flight.
  assign finished = (state_q == ST_DONE) && !mac_busy;
  assign load     = finished && (!out_valid_q || !out_stall_i);

  assign wr_sample.re = sample_re_i;
  assign wr_sample.im = sample_im_i;

  // The window write happens at the accept edge, so every read of the sweep
  // that follows already sees the new sample; no forwarding is needed.
  always_comb begin
    x_ctrl = '0;
    y_ctrl = '0;
    if (accept) begin
      unique case (req)
        REQ_ADD_X: x_ctrl.add   = 1'b1;
        REQ_ADD_Y: y_ctrl.add   = 1'b1;
        REQ_CLR_X: x_ctrl.clear = 1'b1;
        REQ_CLR_Y: y_ctrl.clear = 1'b1;
        default:   x_ctrl.add   = 1'b0;
      endcase
    end
    if (state_q == ST_SWEEP) begin
      x_ctrl.rd    = 1'b1;
      y_ctrl.rd    = 1'b1;
      x_ctrl.first = (cnt_q == '0);
      y_ctrl.first = (cnt_q == '0);
    end
  end

  swc_window #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_x_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (x_ctrl),
    .wr_sample_i (wr_sample),
    .rd_sample_o (x_sample),
    .rd_strobe_o (x_strobe)
  );

  swc_window #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_y_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (y_ctrl),
    .wr_sample_i (wr_sample),
    .rd_sample_o (y_sample),
    .rd_strobe_o (y_strobe)
  );

  swc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (accept),
    .valid_i   (x_strobe & y_strobe),
    .complex_i (complex_q),
    .x_i       (x_sample),
    .y_i       (y_sample),
    .busy_o    (mac_busy),
    .acc_re_o  (acc_re),
    .acc_im_o  (acc_im)
  );

  // Sequencer, configuration register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      complex_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        complex_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (sweep_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      corr_re_q <= acc_re;
      corr_im_q <= acc_im;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corr_re_o   = corr_re_q;
  assign corr_im_o   = corr_im_q;

  // Both window read pipelines must stay in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_strobe == y_strobe)
    else $error("window read strobes out of step");

  // A result is never loaded while products are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !mac_busy && !x_strobe)
    else $error("result loaded before the sum was complete");

  // No window read is issued outside a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SWEEP) |=> !x_strobe || $past(state_q == ST_SWEEP, 1))
    else $error("window read outside a sweep");

  // An accepted request always starts a sweep from the first entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SWEEP) && (cnt_q == '0))
    else $error("sweep did not start after an accepted request");

endmodule

FILE: rtl/core/swc_window.sv
// ----------------------------------------------------------------------------
// swc_window: one sample window held in a synchronous memory
// Keeps the fill count and the ring position of the oldest sample, writes
// new samples and walks the window from oldest to newest during a sweep.
// ----------------------------------------------------------------------------
module swc_window import swc_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  win_ctrl_t ctrl_i,
  input  sample_t   wr_sample_i,
  output sample_t   rd_sample_o,
  output logic      rd_strobe_o
);

  localparam int unsigned AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_LENGTH + 1);

  sample_t        mem_q [WINDOW_LENGTH];
  sample_t        rd_data_q;
  logic           rd_live_q;
  logic           rd_strobe_q;
  logic [CW-1:0]  fill_q;
  logic [AW-1:0]  oldest_q;
  logic [AW-1:0]  rd_ptr_q;
  logic [CW-1:0]  remain_q;

  logic           full;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  remain;
  logic           rd_live;

  // Entries at or beyond the fill count are stale after a clear; the
  // remaining-count masks them to zero instead of a clearing pass.
  assign full    = (fill_q == CW'(WINDOW_LENGTH));
  assign wr_addr = full ? oldest_q : fill_q[AW-1:0];
  assign rd_addr = ctrl_i.first ? oldest_q : rd_ptr_q;
  assign remain  = ctrl_i.first ? fill_q : remain_q;
  assign rd_live = (remain != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      oldest_q    <= '0;
      rd_ptr_q    <= '0;
      remain_q    <= '0;
      rd_live_q   <= 1'b0;
      rd_strobe_q <= 1'b0;
    end else begin
      rd_strobe_q <= ctrl_i.rd;
      if (ctrl_i.clear) begin
        fill_q   <= '0;
        oldest_q <= '0;
      end else if (ctrl_i.add) begin
        if (full) begin
          oldest_q <= (oldest_q == AW'(WINDOW_LENGTH - 1)) ? '0 : oldest_q + 1'b1;
        end else begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (ctrl_i.rd) begin
        rd_ptr_q  <= (rd_addr == AW'(WINDOW_LENGTH - 1)) ? '0 : rd_addr + 1'b1;
        remain_q  <= rd_live ? remain - CW'(1) : remain;
        rd_live_q <= rd_live;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add) begin
      mem_q[wr_addr] <= wr_sample_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_sample_o = rd_live_q ? rd_data_q : '0;
  assign rd_strobe_o = rd_strobe_q;

endmodule

FILE: rtl/core/swc_mac.sv
// ----------------------------------------------------------------------------
// swc_mac: complex multiply-accumulate datapath
// Registers the four partial products of one sample pair, then adds the
// real or complex product into 42-bit wrapping accumulators.
// ----------------------------------------------------------------------------
module swc_mac import swc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    valid_i,
  input  logic                    complex_i,
  input  sample_t                 x_i,
  input  sample_t                 y_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] acc_re_o,
  output logic signed [ACC_W-1:0] acc_im_o
);

  logic                    prod_valid_q;
  logic signed [PROD_W-1:0] ac_q, bd_q, ad_q, bc_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0] ac_ext, bd_ext, ad_ext, bc_ext;
  logic signed [ACC_W-1:0] re_term, im_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ac_q <= PROD_W'(x_i.re) * PROD_W'(y_i.re);
      bd_q <= PROD_W'(x_i.im) * PROD_W'(y_i.im);
      ad_q <= PROD_W'(x_i.re) * PROD_W'(y_i.im);
      bc_q <= PROD_W'(x_i.im) * PROD_W'(y_i.re);
    end
  end

  assign ac_ext = {{(ACC_W - PROD_W){ac_q[PROD_W-1]}}, ac_q};
  assign bd_ext = {{(ACC_W - PROD_W){bd_q[PROD_W-1]}}, bd_q};
  assign ad_ext = {{(ACC_W - PROD_W){ad_q[PROD_W-1]}}, ad_q};
  assign bc_ext = {{(ACC_W - PROD_W){bc_q[PROD_W-1]}}, bc_q};

  // Real mode ignores the imaginary parts entirely.
  assign re_term = complex_i ? ac_ext - bd_ext : ac_ext;
  assign im_term = complex_i ? ad_ext + bc_ext : '0;

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (prod_valid_q) begin
      acc_re_q <= acc_re_q + re_term;
      acc_im_q <= acc_im_q + im_term;
    end
  end

  assign busy_o   = valid_i | prod_valid_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule
